/* sv/dahdsr_pkg.sv */
`default_nettype none

package dahdsr_pkg;

  // Envelope stage codes.
  localparam int unsigned STAGE_W = 3;
  localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [STAGE_W-1:0] ST_DELAY   = 3'd1;
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd2;
  localparam logic [STAGE_W-1:0] ST_HOLD    = 3'd3;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd4;
  localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd5;
  localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd6;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_INC   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_INC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_INC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_INC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_INC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEFF = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_COEFF   = 3'd7;

endpackage

`default_nettype wire

/* sv/dahdsr_envelope_generator.sv */
`default_nettype none

// DAHDSR envelope generator. One input word per audio sample carries a gate bit
// and a trigger bit; each accepted word yields exactly one output word with the
// envelope level (unsigned Q1.LEVEL_FRAC_BITS).
// Input channel: in_valid_i / in_stall_o with gate_i and trigger_i.
// Output channel: out_valid_o / out_stall_i with level_out_o.
// The envelope state is updated in the cycle a word is accepted, and its result
// is registered into the output buffer. One word is accepted every cycle while
// in_stall_o is low; the state update is one pass through one shared multiplier,
// used by attack interpolation or by decay/release scaling.
// Results go into a two-word output buffer. While the receiver stalls, the
// head word holds still and one more input word is taken into the second slot;
// after that in_stall_o is high until the receiver takes a word.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i with no
// wait; the user must write it only while the block is idle, as it is not enforced.
// Reset clears the envelope to idle at level zero, empties the output buffer,
// sets all increments and coefficients to zero and the sustain level to 1.0.
module dahdsr_envelope_generator
  import dahdsr_pkg::*;
#(
  parameter int unsigned LEVEL_FRAC_BITS = 23,
  parameter int unsigned PHASE_FRAC_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          gate_i,
  input  wire logic                          trigger_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [LEVEL_FRAC_BITS:0]           level_out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [((PHASE_FRAC_BITS > LEVEL_FRAC_BITS) ?
                      PHASE_FRAC_BITS : LEVEL_FRAC_BITS):0] cfg_data_i
);

  localparam int unsigned LW  = LEVEL_FRAC_BITS + 1;
  localparam int unsigned PW  = PHASE_FRAC_BITS + 1;
  localparam int unsigned AW  = PHASE_FRAC_BITS + 2;
  localparam int unsigned MW  = (PW > LW) ? PW : LW;
  localparam int unsigned PRW = MW + LW;

  localparam logic [LW-1:0] ONE_L = LW'(1) << LEVEL_FRAC_BITS;
  localparam logic [AW-1:0] ONE_P = AW'(1) << PHASE_FRAC_BITS;
  localparam logic [LW-1:0] MIN_SUSTAIN =
      LW'(((64'd1 << LEVEL_FRAC_BITS) + 64'd500) / 64'd1000);

  // Configuration registers.
  logic [PW-1:0] delay_inc_q, attack_inc_q, hold_inc_q, decay_inc_q, release_inc_q;
  logic [LW-1:0] sustain_q, decay_coeff_q, release_coeff_q;

  // Envelope state.
  logic [STAGE_W-1:0] stage_q, stage_d;
  logic [AW-1:0]      acc_q, acc_d;
  logic [LW-1:0]      env_q, env_d;
  logic [LW-1:0]      start_q, start_d;
  logic               prev_gate_q, prev_trig_q;

  // Output buffer.
  logic          head_vld_q, skid_vld_q;
  logic [LW-1:0] head_q, skid_q;

  logic push, pop;

  logic [4:0]         nz;
  logic               rise;
  logic [STAGE_W-1:0] s1;
  logic [LW-1:0]      lvl1, start1;
  logic [AW-1:0]      acc1, acc_sum;
  logic [PW-1:0]      inc_sel;
  logic               done, is_attack, neg;
  logic [LW-1:0]      coeff_sel, mag, op_b, att_term, scaled, sus_used;
  logic [MW-1:0]      op_a;
  logic [PRW-1:0]     prod;
  logic [LW:0]        att_sum, step, pos_sum;
  logic [LW-1:0]      att_lvl;

  // First live stage at or after the given one; nz flags live timed stages.
  function automatic logic [STAGE_W-1:0] next_live(input logic [STAGE_W-1:0] first,
                                                   input logic gat,
                                                   input logic [4:0] live);
    logic [STAGE_W-1:0] res;
    if (first <= ST_DELAY && live[0]) begin
      res = ST_DELAY;
    end else if (first <= ST_ATTACK && live[1]) begin
      res = ST_ATTACK;
    end else if (first <= ST_HOLD && live[2]) begin
      res = ST_HOLD;
    end else if (first <= ST_DECAY && live[3]) begin
      res = ST_DECAY;
    end else if (gat) begin
      res = ST_SUSTAIN;
    end else if (live[4]) begin
      res = ST_RELEASE;
    end else begin
      res = ST_IDLE;
    end
    return res;
  endfunction

  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign level_out_o = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_inc_q     <= '0;
      attack_inc_q    <= '0;
      hold_inc_q      <= '0;
      decay_inc_q     <= '0;
      release_inc_q   <= '0;
      sustain_q       <= ONE_L;
      decay_coeff_q   <= '0;
      release_coeff_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DELAY_INC:   delay_inc_q     <= cfg_data_i[PW-1:0];
        CFG_ATTACK_INC:  attack_inc_q    <= cfg_data_i[PW-1:0];
        CFG_HOLD_INC:    hold_inc_q      <= cfg_data_i[PW-1:0];
        CFG_DECAY_INC:   decay_inc_q     <= cfg_data_i[PW-1:0];
        CFG_RELEASE_INC: release_inc_q   <= cfg_data_i[PW-1:0];
        CFG_SUSTAIN:     sustain_q       <= cfg_data_i[LW-1:0];
        CFG_DECAY_COEFF: decay_coeff_q   <= cfg_data_i[LW-1:0];
        CFG_REL_COEFF:   release_coeff_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nz = {release_inc_q != '0, decay_inc_q != '0, hold_inc_q != '0,
          attack_inc_q != '0, delay_inc_q != '0};
    rise = (trigger_i && !prev_trig_q) || (gate_i && !prev_gate_q);

    s1   = stage_q;
    lvl1 = env_q;
    acc1 = acc_q;
    if (rise) begin
      s1 = next_live(ST_DELAY, gate_i, nz);
      if (s1 != ST_DELAY && s1 != ST_ATTACK) begin
        lvl1 = ONE_L;
      end
      acc1 = '0;
    end
    // A falling gate forces release, or idle if nz[4] is low, from any active stage.
    if (s1 != ST_IDLE && s1 != ST_RELEASE && prev_gate_q && !gate_i) begin
      s1   = nz[4] ? ST_RELEASE : ST_IDLE;
      acc1 = '0;
    end
    start1 = (acc1 == '0) ? lvl1 : start_q;

    case (s1)
      ST_DELAY:   inc_sel = delay_inc_q;
      ST_ATTACK:  inc_sel = attack_inc_q;
      ST_HOLD:    inc_sel = hold_inc_q;
      ST_DECAY:   inc_sel = decay_inc_q;
      ST_RELEASE: inc_sel = release_inc_q;
      default:    inc_sel = '0;
    endcase
    acc_sum = acc1 + AW'(inc_sel);
    done    = acc_sum > ONE_P;

    // One multiplier serves attack interpolation and exponential scaling.
    is_attack = (s1 == ST_ATTACK);
    coeff_sel = (s1 == ST_DECAY) ? decay_coeff_q : release_coeff_q;
    neg       = coeff_sel[LW-1];
    mag       = neg ? (LW'(0) - coeff_sel) : coeff_sel;
    op_a      = is_attack ? MW'(acc_sum[PW-1:0]) : MW'(lvl1);
    op_b      = is_attack ? (ONE_L - start1) : mag;
    prod      = PRW'(op_a) * PRW'(op_b);

    att_term = LW'(prod >> PHASE_FRAC_BITS);
    att_sum  = (LW+1)'(start1) + (LW+1)'(att_term);
    att_lvl  = (att_sum > (LW+1)'(ONE_L)) ? ONE_L : att_sum[LW-1:0];

    step    = (LW+1)'(prod >> LEVEL_FRAC_BITS);
    pos_sum = (LW+1)'(lvl1) + step;
    if (neg) begin
      scaled = (step >= (LW+1)'(lvl1)) ? '0 : (lvl1 - step[LW-1:0]);
    end else begin
      scaled = (pos_sum > (LW+1)'(ONE_L)) ? ONE_L : pos_sum[LW-1:0];
    end

    if (sustain_q == '0) begin
      sus_used = MIN_SUSTAIN;
    end else if (sustain_q > ONE_L) begin
      sus_used = ONE_L;
    end else begin
      sus_used = sustain_q;
    end

    stage_d = s1;
    env_d   = lvl1;
    acc_d   = acc1;
    start_d = start1;
    case (s1)
      ST_DELAY: begin
        if (done) begin
          stage_d = next_live(ST_ATTACK, gate_i, nz);
          acc_d   = '0;
        end else begin
          acc_d = acc_sum;
        end
      end
      ST_ATTACK: begin
        if (done) begin
          stage_d = next_live(ST_HOLD, gate_i, nz);
          env_d   = ONE_L;
          acc_d   = '0;
        end else begin
          acc_d = acc_sum;
          env_d = att_lvl;
        end
      end
      ST_HOLD: begin
        if (done) begin
          stage_d = next_live(ST_DECAY, gate_i, nz);
          acc_d   = '0;
        end else begin
          acc_d = acc_sum;
        end
      end
      ST_DECAY: begin
        if (done) begin
          stage_d = next_live(ST_SUSTAIN, gate_i, nz);
          env_d   = sus_used;
          acc_d   = '0;
        end else begin
          acc_d = acc_sum;
          env_d = scaled;
        end
      end
      ST_SUSTAIN: begin
        env_d = sus_used;
      end
      ST_RELEASE: begin
        if (done) begin
          stage_d = ST_IDLE;
          env_d   = '0;
          acc_d   = '0;
        end else begin
          acc_d = acc_sum;
          env_d = scaled;
        end
      end
      default: begin
        env_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= ST_IDLE;
      acc_q       <= '0;
      env_q       <= '0;
      start_q     <= '0;
      prev_gate_q <= 1'b0;
      prev_trig_q <= 1'b0;
    end else if (push) begin
      stage_q     <= stage_d;
      acc_q       <= acc_d;
      env_q       <= env_d;
      start_q     <= start_d;
      prev_gate_q <= gate_i;
      prev_trig_q <= trigger_i;
    end
  end

  // Output buffer control: the head word is what the receiver sees.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop) begin
      if (skid_vld_q) begin
        skid_vld_q <= push;
      end else begin
        head_vld_q <= push;
      end
    end else if (push) begin
      if (head_vld_q) begin
        skid_vld_q <= 1'b1;
      end else begin
        head_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) begin
        head_q <= skid_q;
        if (push) begin
          skid_q <= env_d;
        end
      end else if (push) begin
        head_q <= env_d;
      end
    end else if (push) begin
      if (head_vld_q) begin
        skid_q <= env_d;
      end else begin
        head_q <= env_d;
      end
    end
  end

  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> head_vld_q)
    else $error("second buffer slot holds a word while the head slot is empty");

  a_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop && head_vld_q) |=> skid_vld_q)
    else $error("word accepted during a stall was not kept in the second slot");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push |=> env_q <= ONE_L))
    else $error("envelope level exceeds full scale");

  a_stage_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q <= ST_RELEASE)
    else $error("envelope reached the unused stage code");

endmodule

`default_nettype wire
